@@ hw/rtl/bac_pkg.sv @@
`default_nettype none

package bac_pkg;

	localparam int unsigned BUTTON_BITS_DEF = 32;
	localparam int unsigned TIME_BITS_DEF   = 32;
	localparam int unsigned IDX_BITS        = 5;
	localparam int unsigned CFG_IDX_BITS    = 3;
	localparam int unsigned CFG_DATA_BITS   = 32;
	localparam logic [15:0] MIN_RATE        = 16'd50;

	localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
	localparam logic [1:0] FUNC_CAPTURE = 2'd1;
	localparam logic [1:0] FUNC_CANCEL  = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_GEAR_UP_MASK   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GEAR_DOWN_MASK = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ERG_MASK       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_DELAY   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_RATE    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE         = 3'd5;

	typedef struct packed {
		logic step;
		logic release_all;
	} act_ctl_t;

	typedef struct packed {
		logic                capturing;
		logic                candidate_valid;
		logic                capture_done;
		logic [IDX_BITS-1:0] captured_index;
	} cap_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/bac_cfg_regs.sv @@
`default_nettype none

module bac_cfg_regs #(
	parameter int unsigned BUTTON_BITS = bac_pkg::BUTTON_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bac_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [bac_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic [BUTTON_BITS-1:0]                up_mask,
	output logic [BUTTON_BITS-1:0]                down_mask,
	output logic [BUTTON_BITS-1:0]                erg_mask,
	output logic [15:0]                           delay,
	output logic [15:0]                           rate,
	output logic                                  enabled,
	output logic                                  disable_pulse
);

	logic [BUTTON_BITS-1:0] up_mask_q;
	logic [BUTTON_BITS-1:0] down_mask_q;
	logic [BUTTON_BITS-1:0] erg_mask_q;
	logic [15:0]            delay_q;
	logic [15:0]            rate_q;
	logic                   enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_mask_q   <= '0;
			down_mask_q <= '0;
			erg_mask_q  <= '0;
			delay_q     <= '0;
			rate_q      <= bac_pkg::MIN_RATE;
			enabled_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bac_pkg::REG_GEAR_UP_MASK:   up_mask_q   <= BUTTON_BITS'(cfg_data);
				bac_pkg::REG_GEAR_DOWN_MASK: down_mask_q <= BUTTON_BITS'(cfg_data);
				bac_pkg::REG_ERG_MASK:       erg_mask_q  <= BUTTON_BITS'(cfg_data);
				bac_pkg::REG_REPEAT_DELAY:   delay_q     <= cfg_data[15:0];
				bac_pkg::REG_REPEAT_RATE:    rate_q      <= cfg_data[15:0];
				bac_pkg::REG_ENABLE:         enabled_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign up_mask       = up_mask_q;
	assign down_mask     = down_mask_q;
	assign erg_mask      = erg_mask_q;
	assign delay         = delay_q;
	// clamp the repeat interval to its floor
	assign rate          = (rate_q < bac_pkg::MIN_RATE) ? bac_pkg::MIN_RATE : rate_q;
	assign enabled       = enabled_q;
	assign disable_pulse = cfg_wr_en && (cfg_index == bac_pkg::REG_ENABLE) && !cfg_data[0];

endmodule

`default_nettype wire

@@ hw/rtl/bac_action.sv @@
`default_nettype none

module bac_action #(
	parameter int unsigned BUTTON_BITS = bac_pkg::BUTTON_BITS_DEF,
	parameter int unsigned TIME_BITS   = bac_pkg::TIME_BITS_DEF,
	parameter bit          MAY_REPEAT  = 1'b1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bac_pkg::act_ctl_t      ctl,
	input  wire logic [BUTTON_BITS-1:0] mask,
	input  wire logic [BUTTON_BITS-1:0] buttons,
	input  wire logic [TIME_BITS-1:0]   now_t,
	input  wire logic [15:0]            delay,
	input  wire logic [15:0]            rate,
	output logic                        fire
);

	logic                 down_q;
	logic [TIME_BITS-1:0] next_q;
	logic                 hit;
	logic [TIME_BITS-1:0] diff;
	logic                 due;

	assign hit  = |(mask & buttons);
	assign diff = now_t - next_q;
	// wrap-safe compare: due once now has reached next
	assign due  = MAY_REPEAT && (delay != 16'd0) && !diff[TIME_BITS-1];
	assign fire = ctl.step && hit && (!down_q || due);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q <= 1'b0;
			next_q <= '0;
		end else if (ctl.release_all) begin
			down_q <= 1'b0;
		end else if (ctl.step) begin
			down_q <= hit;
			if (hit && !down_q) begin
				next_q <= now_t + TIME_BITS'(delay);
			end else if (hit && due) begin
				next_q <= now_t + TIME_BITS'(rate);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.release_all |=> !down_q)
		else $error("action still down after release");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && !ctl.release_all && hit && !down_q) |=> (down_q && next_q == $past(now_t + TIME_BITS'(delay))))
		else $error("fresh press did not arm repeat timer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!ctl.step && !ctl.release_all) |=> ($stable(down_q) && $stable(next_q)))
		else $error("action state moved without a sample");

endmodule

`default_nettype wire

@@ hw/rtl/bac_capture.sv @@
`default_nettype none

module bac_capture #(
	parameter int unsigned BUTTON_BITS = bac_pkg::BUTTON_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic [1:0]             func,
	input  wire logic                   pad,
	input  wire logic [BUTTON_BITS-1:0] buttons,
	input  wire logic                   enabled,
	output logic                        cap_on,
	output bac_pkg::cap_stat_t          stat,
	output logic [BUTTON_BITS-1:0]      held_next
);

	logic                         cap_on_q;
	logic                         cap_on_d;
	logic [BUTTON_BITS-1:0]       held_q;
	logic [BUTTON_BITS-1:0]       held_d;
	logic [BUTTON_BITS-1:0]       base_q;
	logic [BUTTON_BITS-1:0]       base_d;
	logic                         pend_v_q;
	logic                         pend_v_d;
	logic [bac_pkg::IDX_BITS-1:0] pend_idx_q;
	logic [bac_pkg::IDX_BITS-1:0] pend_idx_d;
	logic                         done;
	logic [BUTTON_BITS-1:0]       fresh;
	logic [bac_pkg::IDX_BITS-1:0] fresh_idx;
	logic [31:0]                  btn_wide;

	assign fresh    = buttons & ~base_q;
	assign btn_wide = 32'(buttons);

	// lowest set bit of the fresh word
	always_comb begin
		fresh_idx = '0;
		for (int i = BUTTON_BITS - 1; i >= 0; i--) begin
			if (fresh[i]) begin
				fresh_idx = bac_pkg::IDX_BITS'(i);
			end
		end
	end

	always_comb begin
		cap_on_d   = cap_on_q;
		held_d     = held_q;
		base_d     = base_q;
		pend_v_d   = pend_v_q;
		pend_idx_d = pend_idx_q;
		done       = 1'b0;
		if (advance) begin
			case (func)
				bac_pkg::FUNC_CAPTURE: begin
					cap_on_d   = 1'b1;
					base_d     = held_q;
					pend_v_d   = 1'b0;
					pend_idx_d = '0;
				end
				bac_pkg::FUNC_CANCEL: begin
					cap_on_d   = 1'b0;
					base_d     = '0;
					pend_v_d   = 1'b0;
					pend_idx_d = '0;
				end
				bac_pkg::FUNC_SAMPLE: begin
					if ((!enabled && !cap_on_q) || !pad) begin
						held_d = '0;
					end else begin
						held_d = buttons;
						if (cap_on_q) begin
							// forget baseline buttons once they are let go
							base_d = base_q & buttons;
							if (!pend_v_q) begin
								if (|fresh) begin
									pend_v_d   = 1'b1;
									pend_idx_d = fresh_idx;
								end
							end else if (!btn_wide[pend_idx_q]) begin
								done       = 1'b1;
								cap_on_d   = 1'b0;
								base_d     = '0;
								pend_v_d   = 1'b0;
								pend_idx_d = '0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_on_q   <= 1'b0;
			held_q     <= '0;
			base_q     <= '0;
			pend_v_q   <= 1'b0;
			pend_idx_q <= '0;
		end else begin
			cap_on_q   <= cap_on_d;
			held_q     <= held_d;
			base_q     <= base_d;
			pend_v_q   <= pend_v_d;
			pend_idx_q <= pend_idx_d;
		end
	end

	assign cap_on                = cap_on_q;
	assign held_next             = held_d;
	assign stat.capturing        = cap_on_d;
	assign stat.candidate_valid  = pend_v_d;
	assign stat.capture_done     = done;
	assign stat.captured_index   = done ? pend_idx_q : (pend_v_d ? pend_idx_d : '0);

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> cap_on_q)
		else $error("capture candidate pending outside capture mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		!cap_on_q |-> (base_q == '0 && !pend_v_q))
		else $error("capture state left over after capture ended");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !advance) |=> (pend_v_q && $stable(pend_idx_q)))
		else $error("pending index changed without a transfer");

endmodule

`default_nettype wire

@@ hw/rtl/button_action_autorepeat_capture.sv @@
// Button action block with auto-repeat and button capture.
// Input channel (in_valid/in_ready) carries one item per transfer: a button
// sample (func sample) with pad_present, button_word and a wrapping
// millisecond timestamp now_ms, or a begin/cancel capture command.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// action fire flags, capture status, captured_index and held_now.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data,
// taken at once with no handshake; write them only while the block is idle.
// The item lands in the input register, then one pass of compare,
// timestamp add and priority-encode logic writes the result register and
// all state. Throughput is 1 item per cycle while out_ready stays high, set
// by that single pass since every item sees the state the previous one left.
// When out_ready is low the result register holds and one more item may
// wait in the input register; in_ready drops only when both are full.
// Reset clears masks, delay, enable, action and capture state and sets the
// repeat interval to 50 ms; both channels come up empty.
`default_nettype none

module button_action_autorepeat_capture #(
	parameter int unsigned BUTTON_BITS = bac_pkg::BUTTON_BITS_DEF,
	parameter int unsigned TIME_BITS   = bac_pkg::TIME_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [bac_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [bac_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        func,
	input  wire logic                              pad_present,
	input  wire logic [31:0]                       button_word,
	input  wire logic [31:0]                       now_ms,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   fire_gear_up,
	output logic                                   fire_gear_down,
	output logic                                   fire_erg,
	output logic                                   capturing,
	output logic                                   candidate_valid,
	output logic                                   capture_done,
	output logic [bac_pkg::IDX_BITS-1:0]           captured_index,
	output logic [31:0]                            held_now
);

	logic [BUTTON_BITS-1:0] up_mask;
	logic [BUTTON_BITS-1:0] down_mask;
	logic [BUTTON_BITS-1:0] erg_mask;
	logic [15:0]            delay;
	logic [15:0]            rate;
	logic                   enabled;
	logic                   disable_pulse;

	logic                   v_s1;
	logic [1:0]             func_s1;
	logic                   pad_s1;
	logic [BUTTON_BITS-1:0] btn_s1;
	logic [TIME_BITS-1:0]   now_s1;

	logic                   v_s2;
	logic                   up_s2;
	logic                   down_s2;
	logic                   erg_s2;
	bac_pkg::cap_stat_t     stat_s2;
	logic [BUTTON_BITS-1:0] held_s2;

	logic                   advance;
	logic                   cap_on;
	bac_pkg::cap_stat_t     stat;
	logic [BUTTON_BITS-1:0] held_next;
	bac_pkg::act_ctl_t      act_ctl;
	logic                   is_sample;
	logic                   fire_up;
	logic                   fire_down;
	logic                   fire_e;

	bac_cfg_regs #(
		.BUTTON_BITS(BUTTON_BITS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.up_mask      (up_mask),
		.down_mask    (down_mask),
		.erg_mask     (erg_mask),
		.delay        (delay),
		.rate         (rate),
		.enabled      (enabled),
		.disable_pulse(disable_pulse)
	);

	// advance the item in the input register into the result register
	assign advance  = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			pad_s1  <= pad_present;
			btn_s1  <= BUTTON_BITS'(button_word);
			now_s1  <= TIME_BITS'(now_ms);
		end
	end

	assign is_sample           = advance && (func_s1 == bac_pkg::FUNC_SAMPLE);
	assign act_ctl.step        = is_sample && enabled && pad_s1 && !cap_on;
	assign act_ctl.release_all = disable_pulse ||
		(is_sample && (!pad_s1 || (!enabled && !cap_on)));

	bac_capture #(
		.BUTTON_BITS(BUTTON_BITS)
	) u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.func     (func_s1),
		.pad      (pad_s1),
		.buttons  (btn_s1),
		.enabled  (enabled),
		.cap_on   (cap_on),
		.stat     (stat),
		.held_next(held_next)
	);

	bac_action #(
		.BUTTON_BITS(BUTTON_BITS),
		.TIME_BITS  (TIME_BITS),
		.MAY_REPEAT (1'b1)
	) u_gear_up (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (act_ctl),
		.mask   (up_mask),
		.buttons(btn_s1),
		.now_t  (now_s1),
		.delay  (delay),
		.rate   (rate),
		.fire   (fire_up)
	);

	bac_action #(
		.BUTTON_BITS(BUTTON_BITS),
		.TIME_BITS  (TIME_BITS),
		.MAY_REPEAT (1'b1)
	) u_gear_down (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (act_ctl),
		.mask   (down_mask),
		.buttons(btn_s1),
		.now_t  (now_s1),
		.delay  (delay),
		.rate   (rate),
		.fire   (fire_down)
	);

	bac_action #(
		.BUTTON_BITS(BUTTON_BITS),
		.TIME_BITS  (TIME_BITS),
		.MAY_REPEAT (1'b0)
	) u_erg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (act_ctl),
		.mask   (erg_mask),
		.buttons(btn_s1),
		.now_t  (now_s1),
		.delay  (delay),
		.rate   (rate),
		.fire   (fire_e)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= 1'b1;
		end else if (out_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			up_s2   <= fire_up;
			down_s2 <= fire_down;
			erg_s2  <= fire_e;
			stat_s2 <= stat;
			held_s2 <= held_next;
		end
	end

	assign out_valid       = v_s2;
	assign fire_gear_up    = up_s2;
	assign fire_gear_down  = down_s2;
	assign fire_erg        = erg_s2;
	assign capturing       = stat_s2.capturing;
	assign candidate_valid = stat_s2.candidate_valid;
	assign capture_done    = stat_s2.capture_done;
	assign captured_index  = stat_s2.captured_index;
	assign held_now        = 32'(held_s2);

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && stat_s2.capture_done) |-> (!stat_s2.capturing && !stat_s2.candidate_valid))
		else $error("capture reported done while still capturing");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (up_s2 || down_s2 || erg_s2)) |-> (!stat_s2.capturing && !stat_s2.capture_done))
		else $error("action fired during capture");

	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && func_s1 != bac_pkg::FUNC_SAMPLE) |=>
			(!up_s2 && !down_s2 && !erg_s2 && !stat_s2.capture_done))
		else $error("command item produced a fire or capture_done");

endmodule

`default_nettype wire

@@ tb/sv/button_action_autorepeat_capture_tb.sv @@
`timescale 1ns / 1ps

module button_action_autorepeat_capture_tb;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int MAX_REPORTS = 10;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [15:0] REPEAT_FLOOR_MS = 16'd50;

	typedef struct packed {
		logic [1:0]  fn;
		logic        pad;
		logic [31:0] btn;
		logic [31:0] now;
	} sample_item_t;

	typedef struct packed {
		logic                         fire_gear_up;
		logic                         fire_gear_down;
		logic                         fire_erg;
		logic                         capturing;
		logic                         candidate_valid;
		logic                         capture_done;
		logic [bac_pkg::IDX_BITS-1:0] captured_index;
		logic [31:0]                  held_now;
	} action_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_wr_en = 1'b0;
	logic [bac_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [bac_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [1:0]                        func = bac_pkg::FUNC_SAMPLE;
	logic                              pad_present = 1'b0;
	logic [31:0]                       button_word = '0;
	logic [31:0]                       now_ms = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic                              fire_gear_up;
	logic                              fire_gear_down;
	logic                              fire_erg;
	logic                              capturing;
	logic                              candidate_valid;
	logic                              capture_done;
	logic [bac_pkg::IDX_BITS-1:0]      captured_index;
	logic [31:0]                       held_now;

	button_action_autorepeat_capture dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.pad_present    (pad_present),
		.button_word    (button_word),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.fire_gear_up   (fire_gear_up),
		.fire_gear_down (fire_gear_down),
		.fire_erg       (fire_erg),
		.capturing      (capturing),
		.candidate_valid(candidate_valid),
		.capture_done   (capture_done),
		.captured_index (captured_index),
		.held_now       (held_now)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predictor copy of the registers
	logic [31:0] up_mask_r = '0;
	logic [31:0] down_mask_r = '0;
	logic [31:0] erg_mask_r = '0;
	logic [15:0] delay_r = '0;
	logic [15:0] rate_r = 16'd50;
	logic        enable_r = 1'b0;

	// predictor copy of the state
	logic        action_latched [3] = '{1'b0, 1'b0, 1'b0};
	logic [31:0] repeat_due_ms [3] = '{32'd0, 32'd0, 32'd0};
	logic [31:0] held_mirror = '0;
	logic        capture_active = 1'b0;
	logic [31:0] capture_mask = '0;
	logic        cand_valid = 1'b0;
	logic [4:0]  cand_index = '0;

	sample_item_t   pending_items [$];
	action_result_t expected_results [$];

	logic        no_idle = 1'b0;
	logic [31:0] tnow = '0;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	int          n_sent = 0;
	int          n_results = 0;
	int          n_settings = 0;
	int          n_gear_fires = 0;
	int          n_erg_fires = 0;
	int          n_captures = 0;

	function automatic void release_actions();
		for (int k = 0; k < 3; k++)
			action_latched[k] = 1'b0;
	endfunction

	function automatic void drop_capture();
		capture_active = 1'b0;
		capture_mask = '0;
		cand_valid = 1'b0;
		cand_index = '0;
	endfunction

	function automatic logic gear_step(input int k, input logic [31:0] mask,
			input logic [31:0] btn, input logic [31:0] now, input logic may_repeat);
		logic [31:0] period;
		logic [31:0] lag;
		period = (rate_r < REPEAT_FLOOR_MS) ? {16'd0, REPEAT_FLOOR_MS} : {16'd0, rate_r};
		lag = now - repeat_due_ms[k];
		if ((mask & btn) == '0) begin
			action_latched[k] = 1'b0;
			return 1'b0;
		end
		if (!action_latched[k]) begin
			action_latched[k] = 1'b1;
			repeat_due_ms[k] = now + {16'd0, delay_r};
			return 1'b1;
		end
		// wrap-safe: due once now has reached the deadline
		if (may_repeat && delay_r != '0 && !lag[31]) begin
			repeat_due_ms[k] = now + period;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic action_result_t predict_action(input sample_item_t it);
		action_result_t r;
		logic [31:0] fresh;
		r = '0;
		case (it.fn)
		bac_pkg::FUNC_CAPTURE: begin
			capture_active = 1'b1;
			capture_mask = held_mirror;
			cand_valid = 1'b0;
			cand_index = '0;
		end
		bac_pkg::FUNC_CANCEL: drop_capture();
		bac_pkg::FUNC_SAMPLE: begin
			if (!enable_r && !capture_active) begin
				held_mirror = '0;
				release_actions();
			end else if (!it.pad) begin
				release_actions();
				held_mirror = '0;
			end else begin
				held_mirror = it.btn;
				if (capture_active) begin
					capture_mask &= it.btn;
					if (!cand_valid) begin
						fresh = it.btn & ~capture_mask;
						for (int b = 0; b < 32; b++) begin
							if (fresh[b] && !cand_valid) begin
								cand_valid = 1'b1;
								cand_index = b[4:0];
							end
						end
					end else if (!it.btn[cand_index]) begin
						r.capture_done = 1'b1;
						r.captured_index = cand_index;
						n_captures++;
						drop_capture();
					end
				end else if (enable_r) begin
					r.fire_gear_up = gear_step(0, up_mask_r, it.btn, it.now, 1'b1);
					r.fire_gear_down = gear_step(1, down_mask_r, it.btn, it.now, 1'b1);
					r.fire_erg = gear_step(2, erg_mask_r, it.btn, it.now, 1'b0);
				end
			end
		end
		default: ;
		endcase
		r.capturing = capture_active;
		r.candidate_valid = cand_valid;
		if (!r.capture_done)
			r.captured_index = cand_valid ? cand_index : '0;
		r.held_now = held_mirror;
		n_gear_fires += r.fire_gear_up + r.fire_gear_down;
		n_erg_fires += r.fire_erg;
		return r;
	endfunction

	// input side: one item per transfer, a random gap between items unless no_idle is set
	always @(posedge clk or negedge arst_n) begin : driver
		sample_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				it = '{func, pad_present, button_word, now_ms};
				expected_results.push_back(predict_action(it));
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					func <= it.fn;
					pad_present <= it.pad;
					button_word <= it.btn;
					now_ms <= it.now;
					in_valid <= 1'b1;
					send_gap <= no_idle ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check each transfer, then stall at random
	always @(posedge clk or negedge arst_n) begin : monitor
		action_result_t got;
		action_result_t want;
		logic taken;
		int s;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
			hold_left <= 0;
		end else begin
			taken = out_valid && out_ready;
			if (taken) begin
				got = {fire_gear_up, fire_gear_down, fire_erg, capturing, candidate_valid,
					capture_done, captured_index, held_now};
				n_results++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d arrived with nothing expected: %p", n_results, got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("result %0d mismatch (up dn erg cap cand done idx held)",
								n_results);
							$display("  exp %b %b %b %b %b %b %0d %h", want.fire_gear_up,
								want.fire_gear_down, want.fire_erg, want.capturing,
								want.candidate_valid, want.capture_done, want.captured_index,
								want.held_now);
							$display("  got %b %b %b %b %b %b %0d %h", got.fire_gear_up,
								got.fire_gear_down, got.fire_erg, got.capturing,
								got.candidate_valid, got.capture_done, got.captured_index,
								got.held_now);
						end
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (taken && (n_results == 250 || n_results == 1000)) begin
				// long hold-off so the block fills up and stalls its input
				hold_left <= LONG_HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (taken) begin
				s = no_idle ? 0 : $urandom_range(0, 5);
				recv_stall <= (s > 0) ? s - 1 : 0;
				out_ready <= (s == 0);
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_item(input logic [1:0] fn, input logic pad, input logic [31:0] btn,
			input logic [31:0] now);
		pending_items.push_back('{fn, pad, btn, now});
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bac_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		bac_pkg::REG_GEAR_UP_MASK:   up_mask_r = val;
		bac_pkg::REG_GEAR_DOWN_MASK: down_mask_r = val;
		bac_pkg::REG_ERG_MASK:       erg_mask_r = val;
		bac_pkg::REG_REPEAT_DELAY:   delay_r = val[15:0];
		bac_pkg::REG_REPEAT_RATE:    rate_r = val[15:0];
		bac_pkg::REG_ENABLE: begin
			enable_r = val[0];
			if (!val[0])
				release_actions();
		end
		default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] up, input logic [31:0] down,
			input logic [31:0] erg, input logic [15:0] dly, input logic [15:0] rt,
			input logic en, input logic quiet);
		wait_idle();
		write_reg(bac_pkg::REG_GEAR_UP_MASK, up);
		write_reg(bac_pkg::REG_GEAR_DOWN_MASK, down);
		write_reg(bac_pkg::REG_ERG_MASK, erg);
		write_reg(bac_pkg::REG_REPEAT_DELAY, {16'd0, dly});
		write_reg(bac_pkg::REG_REPEAT_RATE, {16'd0, rt});
		write_reg(bac_pkg::REG_ENABLE, {31'd0, en});
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		no_idle = quiet;
		n_settings++;
	endtask

	task automatic gen_items(input int n);
		int made;
		int kind;
		int len;
		int b;
		logic [31:0] hot;
		logic [31:0] word;
		logic [31:0] base;
		made = 0;
		hot = up_mask_r | down_mask_r | erg_mask_r;
		while (made < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				// press and hold action buttons long enough to repeat, then let go
				word = $urandom & hot;
				if ($urandom_range(0, 3) == 0) begin
					b = $urandom_range(0, 31);
					word[b] = 1'b1;
				end
				len = $urandom_range(1, 12);
				repeat (len) begin
					tnow += $urandom_range(0, 140);
					queue_item(bac_pkg::FUNC_SAMPLE, $urandom_range(0, 29) != 0, word, tnow);
					if ($urandom_range(0, 5) == 0) begin
						b = $urandom_range(0, 31);
						word[b] = ~word[b];
					end
				end
				tnow += $urandom_range(1, 140);
				queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, $urandom & ~hot, tnow);
				made += len + 1;
			end else if (kind < 75) begin
				// capture: hold a baseline, press one new button, release it
				b = $urandom_range(0, 31);
				base = $urandom & $urandom;
				base[b] = 1'b0;
				tnow += $urandom_range(0, 140);
				queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, base, tnow);
				queue_item(bac_pkg::FUNC_CAPTURE, 1'($urandom_range(0, 1)), $urandom, $urandom);
				len = $urandom_range(0, 3);
				repeat (len) begin
					tnow += $urandom_range(0, 140);
					queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, base, tnow);
				end
				made += len + 2;
				word = base;
				word[b] = 1'b1;
				len = $urandom_range(1, 4);
				repeat (len) begin
					tnow += $urandom_range(0, 140);
					queue_item(bac_pkg::FUNC_SAMPLE, $urandom_range(0, 15) != 0, word, tnow);
				end
				made += len + 1;
				case ($urandom_range(0, 7))
				0: queue_item(bac_pkg::FUNC_CANCEL, 1'($urandom_range(0, 1)), $urandom, $urandom);
				1: queue_item(bac_pkg::FUNC_CAPTURE, 1'($urandom_range(0, 1)), $urandom,
					$urandom);
				default: begin
					word[b] = 1'b0;
					tnow += $urandom_range(0, 140);
					queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, word, tnow);
				end
				endcase
			end else if (kind < 90) begin
				// noise: any word, any pad state, time may jump anywhere
				if ($urandom_range(0, 1))
					tnow = $urandom;
				else
					tnow += $urandom_range(0, 2000);
				queue_item(bac_pkg::FUNC_SAMPLE, 1'($urandom_range(0, 1)), $urandom, tnow);
				made += 1;
			end else begin
				case ($urandom_range(0, 2))
				0: queue_item(bac_pkg::FUNC_CAPTURE, 1'($urandom_range(0, 1)), $urandom,
					$urandom);
				1: queue_item(bac_pkg::FUNC_CANCEL, 1'($urandom_range(0, 1)), $urandom,
					$urandom);
				default: queue_item(FUNC_UNUSED, 1'($urandom_range(0, 1)), $urandom, $urandom);
				endcase
				made += 1;
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: idle sample, capture works while disabled, unused code
		n_settings = 1;
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'hFFFF_FFFF, 32'd0);
		queue_item(bac_pkg::FUNC_CAPTURE, 1'b0, 32'd0, 32'd0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0005, 32'd10);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0004, 32'd20);
		queue_item(FUNC_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// repeats across the timestamp wrap, rate below the floor
		configure(32'h1, 32'h2, 32'h4, 16'd100, 16'd0, 1'b1, 1'b0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0053);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0054);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0085);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0086);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b0, 32'hFFFF_FFFF, 32'h0000_0090);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0000, 32'h0000_00A0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0004, 32'h0000_00B0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0004, 32'h0000_2800);
		queue_item(bac_pkg::FUNC_CANCEL, 1'b0, 32'h0, 32'h0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0002, 32'h0000_2900);
		queue_item(bac_pkg::FUNC_CAPTURE, 1'b0, 32'h0, 32'h0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h8000_0002, 32'h0000_2A00);
		queue_item(bac_pkg::FUNC_CAPTURE, 1'b0, 32'h0, 32'h0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h8000_0000, 32'h0000_2B00);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h8000_0001, 32'h0000_2C00);
		queue_item(bac_pkg::FUNC_CANCEL, 1'b0, 32'h0, 32'h0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0001, 32'h0000_2D00);
		// disabling releases the held gear up, so the same press fires again
		configure(32'h1, 32'h2, 32'h4, 16'd100, 16'd0, 1'b0, 1'b0);
		configure(32'h1, 32'h2, 32'h4, 16'd100, 16'd0, 1'b1, 1'b0);
		queue_item(bac_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0001, 32'h0000_2E00);

		tnow = 32'h0000_3000;
		configure(32'h0000_000F, 32'h0000_00F0, 32'h0000_0F00, 16'd300, 16'd50, 1'b1, 1'b0);
		gen_items(200);
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'hFFFF, 1'b1, 1'b1);
		gen_items(150);
		configure(32'h8000_0001, 32'h0001_0100, 32'h4000_0000, 16'hFFFF, 16'd10, 1'b1, 1'b0);
		gen_items(150);
		configure(32'h0000_0003, 32'h0000_000C, 32'h0000_0030, 16'd0, 16'd50, 1'b1, 1'b0);
		gen_items(200);
		configure($urandom, $urandom, $urandom, 16'd200, 16'd75, 1'b0, 1'b0);
		gen_items(150);
		configure(32'h0, 32'h0, 32'h0, 16'd120, 16'd60, 1'b1, 1'b1);
		gen_items(100);
		tnow = 32'hFFFF_F000;
		configure(32'h00FF_00FF, 32'hFF00_FF00, 32'h0F0F_0F0F, 16'd50, 16'd49, 1'b1, 1'b0);
		gen_items(250);
		configure($urandom & $urandom, $urandom & $urandom, $urandom & $urandom,
			16'($urandom_range(1, 400)), 16'($urandom_range(0, 200)), 1'b1, 1'b0);
		gen_items(250);

		wait_idle();
		$display("%0d items under %0d register settings, %0d results checked, %0d mismatches",
			n_sent, n_settings, n_results, mismatches);
		$display("gear fires %0d, erg fires %0d, captures completed %0d",
			n_gear_fires, n_erg_fires, n_captures);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
